// ===== sv/cspe_pkg.sv =====
// Shared types and constants of the strided, zero-padded 2D convolution engine.
// No dependencies; every other file of the block imports this package.
package cspe_pkg;

    localparam int DATA_BITS      = 16;
    localparam int SUM_BITS       = 36;
    localparam int IDX_BITS       = 5;
    localparam int MAX_RESULTS    = 42;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 5;

    localparam int DEF_MAX_INPUT  = 16;
    localparam int DEF_MAX_FILTER = 5;
    localparam int DEF_MAX_PAD    = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_SIZE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_SIZE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE_STEP = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAD_WIDTH   = 2'd3;

    localparam logic [4:0] RST_INPUT_SIZE  = 5'd16;
    localparam logic [2:0] RST_FILTER_SIZE = 3'd3;
    localparam logic [2:0] RST_STRIDE_STEP = 3'd1;
    localparam logic [1:0] RST_PAD_WIDTH   = 2'd0;

    // request codes
    localparam logic REQ_COEF  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef struct packed {
        logic                        req_type;
        logic signed [DATA_BITS-1:0] pixel_value;
        logic signed [DATA_BITS-1:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] window_sum;
        logic [IDX_BITS-1:0]        out_row;
        logic [IDX_BITS-1:0]        out_col;
        logic                       last_in_run;
        logic                       image_done;
    } t_out_item;

    // classified command handed from the front to the back
    typedef struct packed {
        logic                        is_pixel;
        logic signed [DATA_BITS-1:0] value;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MAC,
        S_DRAIN,
        S_ADV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic pop;
        logic coef_wr;
        logic pix_step;
        logic win_start;
        logic tap_issue;
        logic win_adv;
        logic out_load;
        logic finish;
    } t_back_ctl;

endpackage

// ===== sv/conv2d_stride_pad_engine.sv =====
// Top level of the strided, zero-padded 2D convolution engine.
// Instantiates cspe_front and cspe_back; depends on cspe_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): an item with
//   req_type coef loads the next kernel coefficient in raster order and
//   restarts the image; an item with req_type pixel delivers the next
//   image pixel in raster order.
//   Output channel (o_out_valid / i_out_stall / o_out_item): one item per
//   finished window, in output raster order, with last_in_run on the final
//   result caused by an input item and image_done on the last window.
//   Configuration port (i_cfg_we / i_cfg_index / i_cfg_data): write only
//   while idle; any write restarts the coefficient load and the image.
// Timing:
//   The front queues up to two items, so the input is taken while the back
//   works. A coefficient is written from the idle state. A pixel is
//   written, then each window it releases passes through a check state,
//   the F*F kernel taps walked one per cycle by the single shared
//   multiply-accumulate, a drain of the read/multiply/add registers, a
//   window-advance state and the output handoff.
//   At most 42 windows leave per pixel; later pixels drain the rest.
// Reset clears all control state and restores the register defaults; the
// kernel and line stores hold garbage until written. When the receiver
// stalls, the result holds in the output register and the back waits.
module conv2d_stride_pad_engine
    import cspe_pkg::*;
#(
    parameter int MAX_INPUT  = DEF_MAX_INPUT,
    parameter int MAX_FILTER = DEF_MAX_FILTER,
    parameter int MAX_PAD    = DEF_MAX_PAD
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_item,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // queue between classification and execution
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    cspe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // stores, window sequencer and MAC
    cspe_back #(
        .MAX_INPUT  (MAX_INPUT),
        .MAX_FILTER (MAX_FILTER),
        .MAX_PAD    (MAX_PAD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sv/cspe_front.sv =====
// Front of the convolution engine: accepts items, classifies them as
// coefficient or pixel, and queues them for the back. Depends on cspe_pkg.
module cspe_front
    import cspe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd_in;

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.is_pixel = (i_in_item.req_type == REQ_PIXEL);
        cmd_in.value    = cmd_in.is_pixel ? i_in_item.pixel_value : i_in_item.coef_value;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

endmodule

// ===== sv/cspe_back.sv =====
// Back of the convolution engine: kernel and line stores, window sequencer,
// shared multiply-accumulate and output register. Depends on cspe_pkg.
module cspe_back
    import cspe_pkg::*;
#(
    parameter int MAX_INPUT  = DEF_MAX_INPUT,
    parameter int MAX_FILTER = DEF_MAX_FILTER,
    parameter int MAX_PAD    = DEF_MAX_PAD
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_cmd_valid,
    input  t_cmd                     i_cmd,
    output logic                     o_cmd_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_item
);

    localparam int LS_COLS = MAX_INPUT + 2 * MAX_PAD;
    localparam int LDEPTH  = MAX_FILTER * LS_COLS;
    localparam int KDEPTH  = MAX_FILTER * MAX_FILTER;
    localparam int LAW     = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int KAW     = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int CCW     = $clog2(KDEPTH + 1);
    localparam int PW      = $clog2(MAX_INPUT + 1);
    localparam int TIW     = (MAX_INPUT > 1) ? $clog2(MAX_INPUT) : 1;
    localparam int FW      = $clog2(MAX_FILTER + 1);
    localparam int SW      = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
    localparam int CW      = $clog2(LS_COLS + MAX_FILTER + 5) + 1;
    localparam int NW      = $clog2(MAX_RESULTS + 1);
    localparam logic signed [CW-1:0] C_ZERO = '0;
    localparam logic signed [CW-1:0] C_ONE  = CW'(1);

    // line-store slot of each image row (row modulo MAX_FILTER)
    function automatic logic [MAX_INPUT*SW-1:0] slot_tab();
        logic [MAX_INPUT*SW-1:0] t;
        int                      s;
        t = '0;
        s = 0;
        for (int r = 0; r < MAX_INPUT; r++) begin
            t[r*SW +: SW] = SW'(s);
            if (s == MAX_FILTER - 1) s = 0;
            else s = s + 1;
        end
        return t;
    endfunction
    localparam logic [MAX_INPUT*SW-1:0] SLOT_TAB = slot_tab();

    // configuration
    logic [4:0] r_input_size;
    logic [2:0] r_filter_size, r_stride;
    logic [1:0] r_pad;
    logic [PW-1:0] eff_s;
    logic [FW-1:0] eff_f;
    logic [2:0]    eff_st;
    logic [1:0]    eff_p;
    logic signed [CW-1:0] s_s, s_f, s_st, s_p, s_pp;
    logic [CCW-1:0] taps;

    // stores and sequencing state
    logic signed [DATA_BITS-1:0] r_line_mem [LDEPTH];
    logic signed [DATA_BITS-1:0] r_kern_mem [KDEPTH];
    t_state r_state, n_state;
    t_back_ctl ctl;
    logic [CCW-1:0] r_coef_cnt;
    logic [PW-1:0]  r_prow, r_pcol;
    logic signed [CW-1:0] r_rb, r_cb;
    logic [IDX_BITS-1:0] r_wi, r_wj, r_res_row, r_res_col;
    logic r_done, r_res_done;
    logic [NW-1:0] r_nres;
    logic [FW-1:0] r_kr, r_kc;
    logic [KAW-1:0] r_kidx;
    logic signed [DATA_BITS-1:0] r_ls_q, r_k_q;
    logic signed [2*DATA_BITS-1:0] r_prod;
    logic r_va, r_vb;
    logic signed [SUM_BITS-1:0] r_acc;
    logic r_out_valid;
    t_out_item r_out;

    logic empty_map, ready, more, out_free, tap_last, tap_ok, col_next, row_next;
    logic signed [CW-1:0] er, ec, er_raw, ec_raw, s_row, s_col, pr, pc;
    logic [SW-1:0] rd_slot, wr_slot;
    logic [LAW-1:0] rd_addr, wr_addr;

    always_comb begin
        eff_s  = (r_input_size == 5'd0) ? PW'(1) :
                 (32'(r_input_size) > MAX_INPUT) ? PW'(MAX_INPUT) : PW'(r_input_size);
        eff_f  = (r_filter_size == 3'd0) ? FW'(1) :
                 (32'(r_filter_size) > MAX_FILTER) ? FW'(MAX_FILTER) : FW'(r_filter_size);
        eff_st = (r_stride == 3'd0) ? 3'd1 : (r_stride > 3'd4) ? 3'd4 : r_stride;
        eff_p  = (32'(r_pad) > MAX_PAD) ? 2'(MAX_PAD) : r_pad;
        s_s    = $signed(CW'(eff_s));
        s_f    = $signed(CW'(eff_f));
        s_st   = $signed(CW'(eff_st));
        s_p    = $signed(CW'(eff_p));
        s_pp   = s_s + s_p + s_p;
        taps   = CCW'(eff_f) * CCW'(eff_f);
    end

    // readiness of the current window: its last needed pixel has arrived
    always_comb begin
        s_row  = $signed(CW'(r_prow));
        s_col  = $signed(CW'(r_pcol));
        er_raw = r_rb + s_f - C_ONE - s_p;
        ec_raw = r_cb + s_f - C_ONE - s_p;
        er = (er_raw < C_ZERO) ? C_ZERO : (er_raw > s_s - C_ONE) ? s_s - C_ONE : er_raw;
        ec = (ec_raw < C_ZERO) ? C_ZERO : (ec_raw > s_s - C_ONE) ? s_s - C_ONE : ec_raw;
        empty_map = s_f > s_pp;
        ready = (s_row >= s_s) || (er < s_row) || ((er == s_row) && (ec < s_col));
        more  = !r_done && !empty_map && ready && (32'(r_nres) < MAX_RESULTS);
        out_free = !r_out_valid || !i_out_stall;
        col_next = (r_cb + s_st + s_f) <= s_pp;
        row_next = (r_rb + s_st + s_f) <= s_pp;
    end

    // tap addressing
    always_comb begin
        pr       = r_rb + $signed(CW'(r_kr)) - s_p;
        pc       = r_cb + $signed(CW'(r_kc)) - s_p;
        tap_ok   = (pr >= C_ZERO) && (pr < s_s) && (pc >= C_ZERO) && (pc < s_s);
        tap_last = (r_kr == eff_f - FW'(1)) && (r_kc == eff_f - FW'(1));
        rd_slot  = SLOT_TAB[TIW'($unsigned(pr))*SW +: SW];
        rd_addr  = LAW'(rd_slot) * LAW'(LS_COLS) + LAW'($unsigned(pc));
        wr_slot  = SLOT_TAB[r_prow[TIW-1:0]*SW +: SW];
        wr_addr  = LAW'(wr_slot) * LAW'(LS_COLS) + LAW'(r_pcol);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_cmd_valid && i_cmd.is_pixel) n_state = S_CHECK;
            S_CHECK: n_state = more ? S_MAC : S_IDLE;
            S_MAC:   if (tap_last) n_state = S_DRAIN;
            S_DRAIN: if (!r_va && !r_vb) n_state = S_ADV;
            S_ADV:   n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_CHECK;
            default: n_state = S_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        ctl = '0;
        case (r_state)
            S_IDLE: begin
                ctl.pop      = i_cmd_valid;
                ctl.coef_wr  = i_cmd_valid && !i_cmd.is_pixel;
                ctl.pix_step = i_cmd_valid && i_cmd.is_pixel;
            end
            S_CHECK: begin
                ctl.win_start = more;
                ctl.finish    = !more;
            end
            S_MAC:   ctl.tap_issue = 1'b1;
            S_ADV:   ctl.win_adv   = 1'b1;
            S_OUT:   ctl.out_load  = out_free;
            default: ctl = '0;
        endcase
    end

    assign o_cmd_pop   = ctl.pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // stores and datapath
    always_ff @(posedge i_clk) begin
        if (ctl.coef_wr) begin
            r_kern_mem[r_coef_cnt[KAW-1:0]] <= i_cmd.value;
        end
        if (ctl.pix_step && (r_prow < eff_s)) begin
            r_line_mem[wr_addr] <= i_cmd.value;
        end
        r_ls_q <= r_line_mem[rd_addr];
        r_k_q  <= r_kern_mem[r_kidx];
        r_prod <= r_ls_q * r_k_q;
        if (ctl.win_start) begin
            r_acc <= '0;
        end else if (r_vb) begin
            r_acc <= r_acc + SUM_BITS'(r_prod);
        end
        if (ctl.win_adv) begin
            r_res_row  <= r_wi;
            r_res_col  <= r_wj;
            r_res_done <= !col_next && !row_next;
        end
        if (ctl.out_load) begin
            r_out.window_sum  <= r_acc;
            r_out.out_row     <= r_res_row;
            r_out.out_col     <= r_res_col;
            r_out.image_done  <= r_res_done;
            r_out.last_in_run <= !more;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_input_size  <= RST_INPUT_SIZE;
            r_filter_size <= RST_FILTER_SIZE;
            r_stride      <= RST_STRIDE_STEP;
            r_pad         <= RST_PAD_WIDTH;
            r_coef_cnt    <= '0;
            r_prow        <= '0;
            r_pcol        <= '0;
            r_rb          <= '0;
            r_cb          <= '0;
            r_wi          <= '0;
            r_wj          <= '0;
            r_done        <= 1'b0;
            r_nres        <= '0;
            r_kr          <= '0;
            r_kc          <= '0;
            r_kidx        <= '0;
            r_va          <= 1'b0;
            r_vb          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_va    <= ctl.tap_issue && tap_ok;
            r_vb    <= r_va;
            if (ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_INPUT_SIZE:  r_input_size  <= i_cfg_data;
                    REG_FILTER_SIZE: r_filter_size <= i_cfg_data[2:0];
                    REG_STRIDE_STEP: r_stride      <= i_cfg_data[2:0];
                    REG_PAD_WIDTH:   r_pad         <= i_cfg_data[1:0];
                    default:         r_pad         <= r_pad;
                endcase
            end

            // restart the image on config writes, coefficient loads and image end
            if (i_cfg_we || ctl.coef_wr ||
                (ctl.finish && (r_prow >= eff_s) && (r_done || empty_map))) begin
                r_prow <= '0;
                r_pcol <= '0;
                r_rb   <= '0;
                r_cb   <= '0;
                r_wi   <= '0;
                r_wj   <= '0;
                r_done <= 1'b0;
            end else if (ctl.pix_step) begin
                r_nres <= '0;
                if (r_prow < eff_s) begin
                    if (r_pcol == eff_s - PW'(1)) begin
                        r_pcol <= '0;
                        r_prow <= r_prow + PW'(1);
                    end else begin
                        r_pcol <= r_pcol + PW'(1);
                    end
                end
            end else if (ctl.win_adv) begin
                r_nres <= r_nres + NW'(1);
                if (col_next) begin
                    r_cb <= r_cb + s_st;
                    r_wj <= r_wj + IDX_BITS'(1);
                end else if (row_next) begin
                    r_rb <= r_rb + s_st;
                    r_wi <= r_wi + IDX_BITS'(1);
                    r_cb <= '0;
                    r_wj <= '0;
                end else begin
                    r_done <= 1'b1;
                end
            end

            if (i_cfg_we) begin
                r_coef_cnt <= '0;
            end else if (ctl.coef_wr) begin
                r_coef_cnt <= (r_coef_cnt + CCW'(1) >= taps) ? '0 : r_coef_cnt + CCW'(1);
            end

            // walk the kernel taps in raster order
            if (ctl.win_start) begin
                r_kr   <= '0;
                r_kc   <= '0;
                r_kidx <= '0;
            end else if (ctl.tap_issue) begin
                r_kidx <= r_kidx + KAW'(1);
                if (r_kc == eff_f - FW'(1)) begin
                    r_kc <= '0;
                    r_kr <= r_kr + FW'(1);
                end else begin
                    r_kc <= r_kc + FW'(1);
                end
            end
        end
    end

    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_nres) <= MAX_RESULTS)
        else $error("result burst exceeds limit");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.image_done |-> r_out.last_in_run)
        else $error("final output of map not marked last of run");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_va && !r_vb))
        else $error("multiply pipeline busy while idle");

    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_coef_cnt < taps))
        else $error("coefficient count out of range");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for conv2d_stride_pad_engine: an own model of the engine predicts every
// window result, which is then compared field by field with what the block sends out.
// Depends on cspe_pkg and the engine RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cspe_pkg::*;

    // Holds the engine's configuration, stores and counters, and the windows still owed.
    class conv_scoreboard;
        t_out_item   owed_q[$];
        int          errors;
        int          n_results;
        logic [4:0]  r_insz;
        logic [2:0]  r_fsz;
        logic [2:0]  r_stp;
        logic [1:0]  r_pad;
        int          kern[25];
        int          lines[100];
        int          coef_cnt, prow, pcol, done_cnt;

        function new();
            r_insz = RST_INPUT_SIZE;
            r_fsz = RST_FILTER_SIZE;
            r_stp = RST_STRIDE_STEP;
            r_pad = RST_PAD_WIDTH;
            foreach (kern[k]) kern[k] = 0;
            foreach (lines[k]) lines[k] = 0;
            coef_cnt = 0;
            prow = 0;
            pcol = 0;
            done_cnt = 0;
            errors = 0;
            n_results = 0;
        endfunction

        function int clamp(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function bit image_busy();
            return prow != 0 || pcol != 0 || done_cnt != 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_INPUT_SIZE:  r_insz = data;
                REG_FILTER_SIZE: r_fsz = data[2:0];
                REG_STRIDE_STEP: r_stp = data[2:0];
                REG_PAD_WIDTH:   r_pad = data[1:0];
                default: ;
            endcase
            coef_cnt = 0;
            prow = 0;
            pcol = 0;
            done_cnt = 0;
        endfunction

        // sum of products of output window (i, j); padding taps contribute nothing
        function longint window_sum(int i, int j, int s, int f, int st, int p);
            longint acc;
            int pr, pc;
            acc = 0;
            for (int kr = 0; kr < f; kr++) begin
                pr = i * st + kr - p;
                if (pr < 0 || pr >= s) continue;
                for (int kc = 0; kc < f; kc++) begin
                    pc = j * st + kc - p;
                    if (pc < 0 || pc >= s) continue;
                    acc += longint'(lines[(pr % 5) * 20 + pc]) * longint'(kern[kr * f + kc]);
                end
            end
            return acc;
        endfunction

        function void note_input(t_in_item it);
            int s, f, st, p, o, total, received, n, er, ec, i, j;
            longint acc;
            t_out_item r;
            s = clamp(r_insz, 1, 16);
            f = clamp(r_fsz, 1, 5);
            st = clamp(r_stp, 1, 4);
            p = clamp(r_pad, 0, 2);
            o = (f > s + 2 * p) ? 0 : (s + 2 * p - f) / st + 1;
            total = o * o;
            n = 0;
            if (it.req_type == REQ_COEF) begin
                // load the tap, wrap the tap count and restart the image
                kern[coef_cnt] = it.coef_value;
                coef_cnt++;
                if (coef_cnt >= f * f) coef_cnt = 0;
                prow = 0;
                pcol = 0;
                done_cnt = 0;
                return;
            end
            if (prow < s) begin
                lines[(prow % 5) * 20 + pcol] = it.pixel_value;
                pcol++;
                if (pcol >= s) begin
                    pcol = 0;
                    prow++;
                end
            end
            received = prow >= s ? s * s : prow * s + pcol;
            // release every window whose last real pixel is in, at most one burst's worth
            while (done_cnt < total && n < MAX_RESULTS) begin
                i = done_cnt / o;
                j = done_cnt % o;
                er = clamp(i * st + f - 1 - p, 0, s - 1);
                ec = clamp(j * st + f - 1 - p, 0, s - 1);
                if (er * s + ec >= received) break;
                acc = window_sum(i, j, s, f, st, p);
                r.window_sum = acc[SUM_BITS-1:0];
                r.out_row = i[IDX_BITS-1:0];
                r.out_col = j[IDX_BITS-1:0];
                r.last_in_run = 1'b0;
                r.image_done = (done_cnt + 1 == total);
                owed_q.push_back(r);
                done_cnt++;
                n++;
            end
            if (n > 0) owed_q[owed_q.size()-1].last_in_run = 1'b1;
            if (prow >= s && done_cnt >= total) begin
                prow = 0;
                pcol = 0;
                done_cnt = 0;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item w;
            n_results++;
            if (owed_q.size() == 0) begin
                $error("unexpected result row %0d col %0d", got.out_row, got.out_col);
                errors++;
                return;
            end
            w = owed_q.pop_front();
            if (got.window_sum !== w.window_sum) begin
                $error("window_sum: expected %0d, got %0d", w.window_sum, got.window_sum);
                errors++;
            end
            if (got.out_row !== w.out_row) begin
                $error("out_row: expected %0d, got %0d", w.out_row, got.out_row);
                errors++;
            end
            if (got.out_col !== w.out_col) begin
                $error("out_col: expected %0d, got %0d", w.out_col, got.out_col);
                errors++;
            end
            if (got.last_in_run !== w.last_in_run) begin
                $error("last_in_run: expected %0b, got %0b", w.last_in_run, got.last_in_run);
                errors++;
            end
            if (got.image_done !== w.image_done) begin
                $error("image_done: expected %0b, got %0b", w.image_done, got.image_done);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_in_item                 i_in_item = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_item                o_out_item;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    conv_scoreboard sb;
    int  n_items = 0;
    int  n_phases = 0;
    bit  calm = 1'b0;    // no idling on either side while set
    int  stall_left = 0;

    conv2d_stride_pad_engine u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check each accepted result, then draw how long to stall before the next one.
    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_item);
                stall_left = calm ? 0 : $urandom_range(0, 7);
                i_out_stall <= (stall_left > 0);
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= (stall_left > 0);
            end
        end
    end

    // Hand one item over; keep valid high afterwards so a back-to-back item never drops it.
    task automatic send_item(t_in_item it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        n_items++;
    endtask

    function automatic logic [15:0] pick_value(bit extreme);
        logic [15:0] corner[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        return extreme ? corner[$urandom_range(0, 3)] : 16'($urandom);
    endfunction

    // Drop valid, wait until every owed window is out, then let the engine settle.
    task automatic drain_all();
        i_in_valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // One image: idle, program all four registers, load taps, stream pixels until the
    // image wraps. noise_pct sprinkles coefficient items that break the image midway.
    task automatic run_image(logic [4:0] insz, logic [4:0] fsz, logic [4:0] stp,
                             logic [4:0] pad, int nload, bit extreme, int noise_pct);
        logic [4:0] vals[4];
        t_in_item   it;
        vals = '{insz, fsz, stp, pad};
        drain_all();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= k[CFG_IDX_BITS-1:0];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            sb.write_reg(k[CFG_IDX_BITS-1:0], vals[k]);
        end
        i_cfg_we <= 1'b0;
        n_phases++;
        for (int k = 0; k < nload; k++) begin
            it.req_type = REQ_COEF;
            it.coef_value = pick_value(extreme);
            it.pixel_value = 16'($urandom);
            send_item(it);
        end
        do begin
            it.pixel_value = pick_value(extreme);
            it.coef_value = 16'($urandom);
            it.req_type = ($urandom_range(1, 100) <= noise_pct) ? REQ_COEF : REQ_PIXEL;
            send_item(it);
        end while (sb.image_busy());
    endtask

    initial begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int s, f;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill all 25 taps with extremes first so no window reads an empty tap
        calm = 1'b1;
        run_image(5'd2, 5'd5, 5'd1, 5'd2, 25, 1'b1, 0);
        calm = 1'b0;
        run_image(5'd1, 5'd1, 5'd1, 5'd0, 1, 1'b1, 0);
        // filter larger than padded image, zero registers clamp up
        run_image(5'd0, 5'd7, 5'd0, 5'd0, 2, 1'b1, 0);
        run_image(5'd3, 5'd6, 5'd7, 5'd3, 3, 1'b1, 0);
        // full-size image with the widest border: overflowing bottom burst
        run_image(5'd31, 5'd1, 5'd1, 5'd2, 1, 1'b0, 0);

        while (n_items < 380) begin
            calm = ($urandom_range(0, 4) == 0);
            s = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(0, 31);
            f = $urandom_range(0, 7);
            run_image(5'(s), 5'(f), 5'($urandom_range(0, 7)), 5'($urandom_range(0, 3)),
                      $urandom_range(0, 4), ($urandom_range(0, 3) == 0),
                      ($urandom_range(0, 3) == 0) ? 3 : 0);
        end
        calm = 1'b0;
        drain_all();

        $display("covered %0d input items over %0d configurations, %0d windows checked",
                 n_items, n_phases, sb.n_results);
        if (sb.errors == 0 && sb.owed_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/cspe_pkg.sv
sv/cspe_front.sv
sv/cspe_back.sv
sv/conv2d_stride_pad_engine.sv
test/tb.sv
